// ===== design/keypad_press_classifier_menu_nav_core_assert.svh =====
// Assertion macros shared by the checker.
`ifndef KEYPAD_PRESS_CLASSIFIER_MENU_NAV_CORE_ASSERT_SVH
`define KEYPAD_PRESS_CLASSIFIER_MENU_NAV_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpc same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define KPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpc next-cycle check failed");

`endif

// ===== design/kpc_pkg.sv =====
`timescale 1ns / 1ps
package kpc_pkg;

    localparam int BUTTON_COUNT = 6;

    localparam logic [7:0] PH_IDLE  = 8'd0;
    localparam logic [7:0] PH_LOCK  = 8'd100;
    localparam logic [7:0] PH_SHORT = 8'd201;
    localparam logic [7:0] PH_LONG  = 8'd202;

    localparam logic [7:0] CURSOR_TOP = 8'd254;

    localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [1:0] REG_RELEASE_HOLD = 2'd1;
    localparam logic [1:0] REG_LAST_SCREEN  = 2'd2;

    localparam logic signed [2:0] DELTA_NONE      = 3'sd0;
    localparam logic signed [2:0] DELTA_INC_SHORT = 3'sd1;
    localparam logic signed [2:0] DELTA_INC_LONG  = 3'sd2;
    localparam logic signed [2:0] DELTA_DEC_SHORT = -3'sd1;
    localparam logic signed [2:0] DELTA_DEC_LONG  = -3'sd2;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } lane_evt_t;

    typedef struct packed {
        logic [BUTTON_COUNT-1:0] shorts;
        logic [BUTTON_COUNT-1:0] longs;
    } kpc_evt_t;

endpackage

// ===== design/kpc_lane.sv =====
`timescale 1ns / 1ps
module kpc_lane
    import kpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       released,
    input  logic [6:0] long_press_ticks,
    input  logic [5:0] release_hold_ticks,
    output lane_evt_t  evt
);

    logic [7:0] phase_reg;
    logic [7:0] phase_next;
    logic [7:0] phase_adv;
    logic [7:0] phase_inc;
    logic [7:0] lock_end;

    assign phase_inc = phase_reg + 8'd1;
    assign lock_end  = PH_LOCK + {2'b00, release_hold_ticks};

    always_comb
    begin
        phase_adv = phase_reg;
        if (phase_reg < PH_LOCK)
        begin
            if (!released)
            begin
                phase_adv = phase_inc;
                if (phase_inc >= {1'b0, long_press_ticks})
                begin
                    phase_adv = PH_LONG;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                phase_adv = PH_SHORT;
            end
        end
        else if ((phase_reg < PH_SHORT) && released)
        begin
            phase_adv = phase_inc;
            if (phase_inc >= lock_end)
            begin
                phase_adv = PH_IDLE;
            end
        end
    end

    assign evt.short_hit = (phase_adv == PH_SHORT);
    assign evt.long_hit  = (phase_adv == PH_LONG);

    // event released: enter lockout
    assign phase_next = (released && (phase_adv >= PH_SHORT)) ? PH_LOCK : phase_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== design/kpc_nav.sv =====
`timescale 1ns / 1ps
module kpc_nav
    import kpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  kpc_evt_t          evt,
    input  logic [2:0]        last_screen,
    output logic signed [2:0] value_delta,
    output logic [7:0]        cursor_next,
    output logic [2:0]        screen_next
);

    logic [7:0] cursor_reg;
    logic [2:0] screen_reg;
    logic [BUTTON_COUNT-1:0] hits;
    logic [7:0] cursor_dn;
    logic [7:0] cursor_up;
    logic [2:0] screen_bk;

    assign hits = evt.shorts | evt.longs;

    always_comb
    begin
        value_delta = DELTA_NONE;
        if (evt.shorts[0])
        begin
            value_delta = DELTA_INC_SHORT;
        end
        if (evt.longs[0])
        begin
            value_delta = DELTA_INC_LONG;
        end
        if (evt.shorts[1])
        begin
            value_delta = DELTA_DEC_SHORT;
        end
        if (evt.longs[1])
        begin
            value_delta = DELTA_DEC_LONG;
        end
    end

    always_comb
    begin
        cursor_dn = cursor_reg;
        if (hits[2] && (cursor_reg != 8'd0))
        begin
            cursor_dn = cursor_reg - 8'd1;
        end
        cursor_up = cursor_dn;
        if (hits[3])
        begin
            cursor_up = (cursor_dn >= CURSOR_TOP) ? 8'd0 : cursor_dn + 8'd1;
        end
        cursor_next = (evt.shorts[4] || evt.shorts[5]) ? 8'd0 : cursor_up;

        screen_bk = screen_reg;
        if (evt.shorts[4] && (screen_reg != 3'd0))
        begin
            screen_bk = screen_reg - 3'd1;
        end
        screen_next = screen_bk;
        if (evt.shorts[5])
        begin
            screen_next = (screen_bk >= last_screen) ? 3'd0 : screen_bk + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= 8'd0;
            screen_reg <= 3'd0;
        end
        else if (advance)
        begin
            cursor_reg <= cursor_next;
            screen_reg <= screen_next;
        end
    end

endmodule

// ===== design/keypad_press_classifier_menu_nav_core.sv =====
`timescale 1ns / 1ps
// Keypad press classifier with menu navigation.
// s_axis carries one scan tick per transfer: six active-low button levels.
// m_axis returns one result per tick: short and long event masks, value
// delta, cursor position and screen number after that tick.
// cfg writes long_press_ticks (0), release_hold_ticks (1), last_screen (2);
// other indexes are ignored. cfg_ready is always high; write only when idle.
// Six button lanes each run a phase counter in parallel; a merge stage turns
// their events into delta, cursor and screen in the same cycle.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one tick per cycle while m_axis_tready is high, set by the single
// output register; a new tick is taken while the previous result is being taken.
// Receiver stall: the output register holds its result and s_axis_tready
// drops until m_axis_tready returns, so no tick is lost or repeated.
// Reset: all phases idle, cursor and screen zero, registers at 10 / 3 / 2,
// output empty.
module keypad_press_classifier_menu_nav_core
    import kpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] button_levels, [7:6] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] short_events, [11:6] long_events,
                                        // [14:12] value_delta, [22:15] cursor_position,
                                        // [25:23] screen_number, [31:26] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [6:0] long_press_ticks_reg;
    logic [5:0] release_hold_ticks_reg;
    logic [2:0] last_screen_reg;

    logic        out_valid_reg;
    logic [25:0] out_data_reg;

    logic                    in_xfer;
    logic [BUTTON_COUNT-1:0] button_levels;
    kpc_evt_t                evt;
    logic signed [2:0]       value_delta;
    logic [7:0]              cursor_next;
    logic [2:0]              screen_next;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign button_levels = s_axis_tdata[BUTTON_COUNT-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg   <= 7'd10;
            release_hold_ticks_reg <= 6'd3;
            last_screen_reg        <= 3'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_PRESS:   long_press_ticks_reg   <= cfg_data;
                REG_RELEASE_HOLD: release_hold_ticks_reg <= cfg_data[5:0];
                REG_LAST_SCREEN:  last_screen_reg        <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < BUTTON_COUNT; gi++)
        begin : g_lane
            lane_evt_t lane_evt;

            kpc_lane u_lane (
                .clk                (clk),
                .rst_n              (rst_n),
                .advance            (in_xfer),
                .released           (button_levels[gi]),
                .long_press_ticks   (long_press_ticks_reg),
                .release_hold_ticks (release_hold_ticks_reg),
                .evt                (lane_evt)
            );

            assign evt.shorts[gi] = lane_evt.short_hit;
            assign evt.longs[gi]  = lane_evt.long_hit;
        end
    endgenerate

    kpc_nav u_nav (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_xfer),
        .evt         (evt),
        .last_screen (last_screen_reg),
        .value_delta (value_delta),
        .cursor_next (cursor_next),
        .screen_next (screen_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= {screen_next, cursor_next, value_delta, evt.longs, evt.shorts};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

// ===== design/kpc_checker.sv =====
`timescale 1ns / 1ps
`include "keypad_press_classifier_menu_nav_core_assert.svh"
module kpc_checker
    import kpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic [5:0]        out_shorts;
    logic [5:0]        out_longs;
    logic signed [2:0] out_delta;

    assign out_shorts = m_axis_tdata[5:0];
    assign out_longs  = m_axis_tdata[11:6];
    assign out_delta  = m_axis_tdata[14:12];

    `KPC_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
    `KPC_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `KPC_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `KPC_ASSERT_SAME(a_events_disjoint, m_axis_tvalid, (out_shorts & out_longs) == 6'd0)
    `KPC_ASSERT_SAME(a_delta_range, m_axis_tvalid, (out_delta >= DELTA_DEC_LONG) && (out_delta <= DELTA_INC_LONG))

endmodule

bind keypad_press_classifier_menu_nav_core kpc_checker u_kpc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import kpc_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int HOLDOFF_CYCLES = 150;

    typedef struct packed {
        logic [5:0] shorts;
        logic [5:0] longs;
        logic [2:0] delta;
        logic [7:0] cursor;
        logic [2:0] screen;
    } tick_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [6:0]  cfg_data = 7'd0;

    // predictor state
    logic [7:0] phase_of [BUTTON_COUNT];
    logic [7:0] cursor_pos;
    logic [2:0] screen_sel;
    logic [6:0] hold_limit;
    logic [5:0] lock_ticks;
    logic [2:0] top_screen;

    logic [5:0]   pending_levels [$];
    tick_result_t expected_results [$];

    int errors;
    int rx_mode;
    bit tx_gaps;
    int hold_req;
    int hold_seen;
    int holdoff_left;
    int rx_count;
    int burst_left;
    int gap_left;

    // stimulus shaping: per-button press/release schedule
    bit btn_down [BUTTON_COUNT];
    int btn_left [BUTTON_COUNT];

    keypad_press_classifier_menu_nav_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic tick_result_t predict_tick(input logic [5:0] levels);
        tick_result_t r;
        int p;
        int s;
        logic [5:0] hit;
        r = '0;
        for (int n = 0; n < BUTTON_COUNT; n++)
        begin
            p = phase_of[n];
            if (p < PH_LOCK)
            begin
                if (!levels[n])
                begin
                    p++;
                    if (p >= hold_limit)
                        p = PH_LONG;
                end
                else if (p >= 1)
                    p = PH_SHORT;
            end
            else if (p < PH_SHORT && levels[n])
            begin
                p++;
                if (p >= PH_LOCK + lock_ticks)
                    p = PH_IDLE;
            end
            phase_of[n] = p[7:0];
            if (phase_of[n] == PH_SHORT)
                r.shorts[n] = 1'b1;
            else if (phase_of[n] == PH_LONG)
                r.longs[n] = 1'b1;
        end

        r.delta = DELTA_NONE;
        if (r.shorts[0])
            r.delta = DELTA_INC_SHORT;
        if (r.longs[0])
            r.delta = DELTA_INC_LONG;
        if (r.shorts[1])
            r.delta = DELTA_DEC_SHORT;
        if (r.longs[1])
            r.delta = DELTA_DEC_LONG;

        hit = r.shorts | r.longs;
        if (hit[2] && cursor_pos != 8'd0)
            cursor_pos = cursor_pos - 8'd1;
        if (hit[3])
            cursor_pos = (cursor_pos >= CURSOR_TOP) ? 8'd0 : cursor_pos + 8'd1;
        if (r.shorts[4])
        begin
            cursor_pos = 8'd0;
            if (screen_sel != 3'd0)
                screen_sel = screen_sel - 3'd1;
        end
        if (r.shorts[5])
        begin
            s = screen_sel + 1;
            cursor_pos = 8'd0;
            screen_sel = (s > top_screen) ? 3'd0 : s[2:0];
        end

        // an event that is released goes straight into lockout
        for (int n = 0; n < BUTTON_COUNT; n++)
            if (levels[n] && phase_of[n] >= PH_SHORT)
                phase_of[n] = PH_LOCK;

        r.cursor = cursor_pos;
        r.screen = screen_sel;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_LONG_PRESS:   hold_limit = data;
            REG_RELEASE_HOLD: lock_ticks = data[5:0];
            REG_LAST_SCREEN:  top_screen = data[2:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_levels.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    task automatic push_random(input int count);
        logic [5:0] levels;
        int press_span;
        press_span = (hold_limit > 106) ? 110 : ((hold_limit < 3) ? 6 : hold_limit + 4);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                levels = 6'($urandom);
            else
            begin
                for (int n = 0; n < BUTTON_COUNT; n++)
                begin
                    if (btn_left[n] == 0)
                    begin
                        btn_down[n] = !btn_down[n];
                        btn_left[n] = btn_down[n] ? $urandom_range(1, press_span)
                                                  : $urandom_range(1, lock_ticks + 6);
                    end
                    btn_left[n]--;
                    levels[n] = !btn_down[n];
                end
            end
            pending_levels.push_back(levels);
        end
    endtask

    task automatic run_phase(input logic [6:0] lpt, input logic [6:0] rht,
                             input logic [6:0] last, input int rxm, input bit gaps,
                             input bit hold, input int count);
        write_reg(REG_LONG_PRESS, lpt);
        write_reg(REG_RELEASE_HOLD, rht);
        write_reg(REG_LAST_SCREEN, last);
        @(negedge clk);
        rx_mode = rxm;
        tx_gaps = gaps;
        push_random(count);
        if (hold)
            hold_req++;
        wait_idle();
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_tick(s_axis_tdata[5:0]));
            if (s_axis_tready || !s_axis_tvalid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_levels.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, pending_levels.pop_front()};
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        if (!tx_gaps)
                            gap_left = 0;
                        else if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(1, 8);
                        else
                            gap_left = $urandom_range(0, 2);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            holdoff_left = 0;
            hold_seen = 0;
            rx_count = 0;
        end
        else
        begin
            rx_count++;
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    3: m_axis_tready <= (rx_count % 5 != 0) && (rx_count % 13 < 9);
                    default: m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    task automatic check_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("short_events", {2'b0, want.shorts}, {2'b0, m_axis_tdata[5:0]});
                check_field("long_events", {2'b0, want.longs}, {2'b0, m_axis_tdata[11:6]});
                check_field("value_delta", {5'b0, want.delta}, {5'b0, m_axis_tdata[14:12]});
                check_field("cursor_position", want.cursor, m_axis_tdata[22:15]);
                check_field("screen_number", {5'b0, want.screen}, {5'b0, m_axis_tdata[25:23]});
            end
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        errors = 0;
        rx_mode = 0;
        tx_gaps = 1'b0;
        hold_req = 0;
        hold_limit = 7'd10;
        lock_ticks = 6'd3;
        top_screen = 3'd2;
        cursor_pos = 8'd0;
        screen_sel = 3'd0;
        for (int n = 0; n < BUTTON_COUNT; n++)
        begin
            phase_of[n] = PH_IDLE;
            btn_down[n] = 1'b0;
            btn_left[n] = $urandom_range(0, 5);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: short press on all, press during lockout, long hold
        @(negedge clk);
        pending_levels.push_back(6'h3F);
        repeat (3) pending_levels.push_back(6'h00);
        pending_levels.push_back(6'h3F);
        pending_levels.push_back(6'h00);
        repeat (4) pending_levels.push_back(6'h3F);
        repeat (12) pending_levels.push_back(6'h00);
        repeat (4) pending_levels.push_back(6'h3F);
        pending_levels.push_back(6'h2A);
        pending_levels.push_back(6'h15);
        wait_idle();
        push_random(120);
        wait_idle();

        run_phase(7'd2, 7'd1, 7'h0F, 1, 1'b1, 1'b1, 120);
        run_phase(7'd99, 7'd49, 7'd0, 2, 1'b1, 1'b0, 120);

        // threshold zero, no lockout; hold button 3 long enough to wrap the cursor
        write_reg(REG_UNUSED, 7'($urandom));
        run_phase(7'd0, 7'd0, 7'd3, 3, 1'b0, 1'b0, 120);
        repeat (270) pending_levels.push_back(6'h37);
        pending_levels.push_back(6'h3F);
        wait_idle();

        run_phase(7'd127, 7'h7F, 7'd1, 1, 1'b1, 1'b0, 120);
        run_phase(7'($urandom_range(2, 20)), 7'($urandom_range(1, 10)),
                  7'($urandom_range(0, 7)), 2, 1'b1, 1'b1, 120);
        run_phase(7'd1, 7'd5, 7'd7, 0, 1'b1, 1'b0, 120);

        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
